// ===== rtl/smr_pkg.sv =====
// Shared types and constants for the spiral matrix reorder unit.
package smr_pkg;

  localparam int unsigned MaxRowsDef = 8;
  localparam int unsigned MaxColsDef = 8;
  localparam int unsigned CfgW       = 4;
  localparam int unsigned DataW      = 32;
  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;

  localparam logic CfgIdxRows = 1'b0;
  localparam logic CfgIdxCols = 1'b1;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_e;

endpackage

// ===== rtl/smr_elem_if.sv =====
// Valid/ready channel carrying one input matrix element.
interface smr_elem_if import smr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

// ===== rtl/smr_result_if.sv =====
// Valid/ready channel carrying one spiral-ordered result element.
interface smr_result_if import smr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] out_value;
  logic                    out_last;

  modport source (output valid, output out_value, output out_last, input ready);
  modport sink (input valid, input out_value, input out_last, output ready);
endinterface

// ===== rtl/spiral_matrix_reorder_unit.sv =====
// Spiral matrix reorder unit: loads a matrix row-major, emits it in clockwise spiral order.
// Load: one element per cycle; the store write happens at the accepting edge.
// Emit: after the last load the state turns to emit, the store read is registered and the
// first result is valid once written to the output queue; then one result per cycle while
// the sink is ready, rows*cols in all (one store read each); next load may start as they drain.
// Reset: sizes return to 8x8 and the load counter clears; the store is not cleared.
module spiral_matrix_reorder_unit import smr_pkg::*; #(
  parameter int unsigned MAX_ROWS = MaxRowsDef,
  parameter int unsigned MAX_COLS = MaxColsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  smr_elem_if.sink           in_if,
  smr_result_if.source       out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [PdataW-1:0]  pwdata,
  output logic [PdataW-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned SRW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned SCW   = $clog2(MAX_COLS + 1);
  localparam int unsigned NW    = $clog2(Depth + 1);
  localparam int unsigned PW    = RW + SCW + 1;

  // configuration
  logic [CfgW-1:0] row_cfg_q, col_cfg_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cfg_q <= CfgW'(8);
      col_cfg_q <= CfgW'(8);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        CfgIdxRows: row_cfg_q <= pwdata[CfgW-1:0];
        CfgIdxCols: col_cfg_q <= pwdata[CfgW-1:0];
        default:    row_cfg_q <= row_cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CfgIdxRows: prdata = PdataW'(row_cfg_q);
      CfgIdxCols: prdata = PdataW'(col_cfg_q);
      default:    prdata = '0;
    endcase
  end

  // clamped sizes
  logic [SRW-1:0] rows_c;
  logic [SCW-1:0] cols_c;
  logic [NW-1:0]  total_c;

  always_comb begin
    if (row_cfg_q == '0) begin
      rows_c = SRW'(1);
    end else if (row_cfg_q > CfgW'(MAX_ROWS)) begin
      rows_c = SRW'(MAX_ROWS);
    end else begin
      rows_c = SRW'(row_cfg_q);
    end
    if (col_cfg_q == '0) begin
      cols_c = SCW'(1);
    end else if (col_cfg_q > CfgW'(MAX_COLS)) begin
      cols_c = SCW'(MAX_COLS);
    end else begin
      cols_c = SCW'(col_cfg_q);
    end
    total_c = NW'((SRW + SCW)'(rows_c) * (SRW + SCW)'(cols_c));
  end

  // control state
  state_e         state_q, state_d;
  dir_e           dir_q, dir_d;
  logic [RW-1:0]  row_q, row_d, top_q, top_d, bot_q, bot_d;
  logic [CW-1:0]  col_q, col_d, lft_q, lft_d, rgt_q, rgt_d;
  logic [SCW-1:0] cols_q, cols_d;
  logic [NW-1:0]  cnt_q, cnt_d;
  logic [NW-1:0]  cnt_inc;
  logic           pend_q, pend_last_q;
  logic           issue_last;

  // output queue
  logic [DataW-1:0] fifo_val_q [2];
  logic             fifo_last_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fcnt_q;
  logic [1:0]       occ;
  logic             push, pop, can_issue, issue, in_acc;

  logic [PW-1:0]    rd_prod;
  logic [AW-1:0]    rd_addr;
  logic [DataW-1:0] rd_data;

  assign in_acc    = in_if.valid & in_if.ready;
  assign push      = pend_q;
  assign pop       = out_if.valid & out_if.ready;
  assign occ       = fcnt_q + {1'b0, pend_q};
  assign can_issue = (occ < 2'd2) || pop;
  assign cnt_inc   = cnt_q + NW'(1);
  assign rd_prod   = PW'(row_q) * PW'(cols_q) + PW'(col_q);
  assign rd_addr   = rd_prod[AW-1:0];

  // next state and sequencer
  always_comb begin
    state_d    = state_q;
    dir_d      = dir_q;
    row_d      = row_q;
    col_d      = col_q;
    top_d      = top_q;
    bot_d      = bot_q;
    lft_d      = lft_q;
    rgt_d      = rgt_q;
    cols_d     = cols_q;
    cnt_d      = cnt_q;
    issue_last = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_inc >= total_c) begin
            cnt_d   = '0;
            state_d = ST_EMIT;
            cols_d  = cols_c;
            dir_d   = DIR_RIGHT;
            row_d   = '0;
            col_d   = '0;
            top_d   = '0;
            lft_d   = '0;
            bot_d   = RW'(rows_c - SRW'(1));
            rgt_d   = CW'(cols_c - SCW'(1));
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      ST_EMIT: begin
        if (issue) begin
          unique case (dir_q)
            DIR_RIGHT: begin
              if (col_q != rgt_q) begin
                col_d = col_q + CW'(1);
              end else if (top_q == bot_q) begin
                issue_last = 1'b1;
              end else begin
                top_d = top_q + RW'(1);
                row_d = top_q + RW'(1);
                dir_d = DIR_DOWN;
              end
            end
            DIR_DOWN: begin
              if (row_q != bot_q) begin
                row_d = row_q + RW'(1);
              end else if (rgt_q == lft_q) begin
                issue_last = 1'b1;
              end else begin
                rgt_d = rgt_q - CW'(1);
                col_d = rgt_q - CW'(1);
                dir_d = DIR_LEFT;
              end
            end
            DIR_LEFT: begin
              if (col_q != lft_q) begin
                col_d = col_q - CW'(1);
              end else if (bot_q == top_q) begin
                issue_last = 1'b1;
              end else begin
                bot_d = bot_q - RW'(1);
                row_d = bot_q - RW'(1);
                dir_d = DIR_UP;
              end
            end
            DIR_UP: begin
              if (row_q != top_q) begin
                row_d = row_q - RW'(1);
              end else if (lft_q == rgt_q) begin
                issue_last = 1'b1;
              end else begin
                lft_d = lft_q + CW'(1);
                col_d = lft_q + CW'(1);
                dir_d = DIR_RIGHT;
              end
            end
            default: dir_d = dir_q;
          endcase
          if (issue_last) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // handshake and memory control
  always_comb begin
    in_if.ready = 1'b0;
    issue       = 1'b0;
    unique case (state_q)
      ST_LOAD: in_if.ready = 1'b1;
      ST_EMIT: issue = can_issue;
      default: in_if.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      dir_q       <= DIR_RIGHT;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
      fcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      dir_q       <= dir_d;
      cnt_q       <= cnt_d;
      pend_q      <= issue;
      pend_last_q <= issue_last;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fcnt_q <= fcnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    col_q  <= col_d;
    top_q  <= top_d;
    bot_q  <= bot_d;
    lft_q  <= lft_d;
    rgt_q  <= rgt_d;
    cols_q <= cols_d;
    if (push) begin
      fifo_val_q[wr_ptr_q]  <= rd_data;
      fifo_last_q[wr_ptr_q] <= pend_last_q;
    end
  end

  smr_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (in_if.element_value),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign out_if.valid     = (fcnt_q != 2'd0);
  assign out_if.out_value = fifo_val_q[rd_ptr_q];
  assign out_if.out_last  = fifo_last_q[rd_ptr_q];

endmodule

// ===== rtl/smr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
